>>> design/cscd_pkg.sv
// ----------------------------------------------------------------------------
// cscd_pkg
// Shared types and codes for the calendar step and DST convert core.
// ----------------------------------------------------------------------------
package cscd_pkg;

    localparam int W_CMD   = 3;
    localparam int W_SEC   = 6;
    localparam int W_MIN   = 6;
    localparam int W_HOUR  = 5;
    localparam int W_WDAY  = 3;
    localparam int W_MDAY  = 5;
    localparam int W_MONTH = 4;
    localparam int W_YEAR  = 7;
    localparam int W_LEVEL = 3;
    localparam int W_OFF   = 4;
    localparam int W_CFG_INDEX = 1;
    localparam int W_CFG_DATA  = 4;

    // stream payload widths, tdata padded to whole bytes
    localparam int W_S_TDATA = 40;
    localparam int W_S_TUSER = W_CMD;
    localparam int W_M_TDATA = 48;

    typedef enum logic [W_CMD-1:0] {
        CMD_ADD_SEC    = 3'd0,
        CMD_NEXT_DAY   = 3'd1,
        CMD_PREV_DAY   = 3'd2,
        CMD_TO_LOCAL   = 3'd3,
        CMD_FROM_LOCAL = 3'd4
    } t_cmd;

    localparam logic [W_LEVEL-1:0] LVL_SEC   = 3'd0;
    localparam logic [W_LEVEL-1:0] LVL_MIN   = 3'd1;
    localparam logic [W_LEVEL-1:0] LVL_HOUR  = 3'd2;
    localparam logic [W_LEVEL-1:0] LVL_DAY   = 3'd3;
    localparam logic [W_LEVEL-1:0] LVL_MONTH = 3'd4;
    localparam logic [W_LEVEL-1:0] LVL_YEAR  = 3'd5;

    localparam logic [W_CFG_INDEX-1:0] CFG_STD_OFFSET = 1'd0;
    localparam logic [W_CFG_INDEX-1:0] CFG_DST_EN     = 1'd1;

    localparam logic [W_OFF-1:0] STD_OFFSET_MAX   = 4'd12;
    localparam logic [W_OFF-1:0] STD_OFFSET_RESET = 4'd1;

    typedef struct packed {
        logic [W_CMD-1:0]   cmd;
        logic [W_SEC-1:0]   sec;
        logic [W_MIN-1:0]   min;
        logic [W_HOUR-1:0]  hour;
        logic [W_WDAY-1:0]  wday;
        logic [W_MDAY-1:0]  mday;
        logic [W_MONTH-1:0] month;
        logic [W_YEAR-1:0]  year;
    } t_in;

    typedef struct packed {
        logic [W_SEC-1:0]   sec;
        logic [W_MIN-1:0]   min;
        logic [W_HOUR-1:0]  hour;
        logic [W_WDAY-1:0]  wday;
        logic [W_MDAY-1:0]  mday;
        logic [W_MONTH-1:0] month;
        logic [W_YEAR-1:0]  year;
        logic [W_LEVEL-1:0] level;
        logic [W_OFF-1:0]   off;
        logic               invalid;
    } t_out;

    typedef struct packed {
        logic [W_OFF-1:0] std_offset;
        logic             dst_en;
    } t_cfg;

endpackage

>>> design/cscd_cfg.sv
// ----------------------------------------------------------------------------
// cscd_cfg
// Configuration registers: standard offset and daylight enable.
// ----------------------------------------------------------------------------
module cscd_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [cscd_pkg::W_CFG_INDEX-1:0] i_cfg_index,
    input  logic [cscd_pkg::W_CFG_DATA-1:0]  i_cfg_wdata,
    output cscd_pkg::t_cfg                   o_cfg
);
    import cscd_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_STD_OFFSET: n_cfg.std_offset = i_cfg_wdata[W_OFF-1:0];
                CFG_DST_EN:     n_cfg.dst_en     = i_cfg_wdata[0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.std_offset <= STD_OFFSET_RESET;
            r_cfg.dst_en     <= 1'b1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> design/cscd_calc.sv
// ----------------------------------------------------------------------------
// cscd_calc
// Single-pass calendar step, offset evaluation and range check for one item.
// ----------------------------------------------------------------------------
module cscd_calc (
    input  cscd_pkg::t_in  i_item,
    input  cscd_pkg::t_cfg i_cfg,
    output cscd_pkg::t_out o_res
);
    import cscd_pkg::*;

    function automatic logic [W_MDAY-1:0] days_in(input logic [W_MONTH-1:0] mon,
                                                  input logic [W_YEAR-1:0]  year);
        logic [W_MDAY-1:0] n;
        case (mon)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
            4'd2:    n = (year[1:0] == 2'd0) ? 5'd29 : 5'd28;
            default: n = 5'd0;
        endcase
        return n;
    endfunction

    logic              bad;
    logic [W_MDAY-1:0] dim_cur;
    logic [W_MDAY-1:0] dim_prev;
    logic [W_WDAY-1:0] dow;
    logic [W_MDAY-1:0] thresh;
    logic              last_sun;
    logic              dst;
    logic [W_OFF-1:0]  off_std;
    logic [W_OFF-1:0]  off;

    // next-day and previous-day candidates
    logic [W_WDAY-1:0]  fwd_wday,  back_wday;
    logic [W_MDAY-1:0]  fwd_mday,  back_mday;
    logic [W_MONTH-1:0] fwd_month, back_month;
    logic [W_YEAR-1:0]  fwd_year,  back_year;
    logic [W_LEVEL-1:0] fwd_level, back_level;

    logic [W_HOUR:0] hour_sum;
    logic [W_HOUR:0] hour_wrap;

    assign dim_cur = days_in(i_item.month, i_item.year);

    assign bad = (i_item.cmd > CMD_FROM_LOCAL) || (i_item.sec > 6'd59) ||
                 (i_item.min > 6'd59) || (i_item.hour > 5'd23) ||
                 (i_item.wday == 3'd0) || (i_item.month == 4'd0) ||
                 (i_item.month > 4'd12) || (i_item.year > 7'd99) ||
                 (i_item.mday == 5'd0) || (i_item.mday > dim_cur);

    // European rule: last Sunday of March and of October
    assign dow      = (i_item.wday == 3'd7) ? 3'd0 : i_item.wday;
    assign thresh   = {2'b00, dow} + 5'd25;
    assign last_sun = (i_item.mday >= 5'd25) && (dow == 3'd0);

    always_comb begin
        dst = 1'b0;
        if (i_item.month > 4'd3 && i_item.month < 4'd10) begin
            dst = 1'b1;
        end else if (i_item.month == 4'd3) begin
            dst = last_sun ? (i_item.hour != 5'd0) : (i_item.mday >= thresh);
        end else if (i_item.month == 4'd10) begin
            dst = last_sun ? (i_item.hour == 5'd0) : (i_item.mday < thresh);
        end
    end

    assign off_std = (i_cfg.std_offset > STD_OFFSET_MAX) ? STD_OFFSET_MAX : i_cfg.std_offset;
    assign off     = bad ? '0 : off_std + {3'b000, (i_cfg.dst_en & dst)};

    // step forward one day
    always_comb begin
        fwd_wday  = (i_item.wday == 3'd7) ? 3'd1 : i_item.wday + 3'd1;
        fwd_mday  = i_item.mday + 5'd1;
        fwd_month = i_item.month;
        fwd_year  = i_item.year;
        fwd_level = LVL_DAY;
        if (i_item.mday == dim_cur) begin
            fwd_mday = 5'd1;
            if (i_item.month == 4'd12) begin
                fwd_month = 4'd1;
                fwd_year  = (i_item.year == 7'd99) ? 7'd0 : i_item.year + 7'd1;
                fwd_level = LVL_YEAR;
            end else begin
                fwd_month = i_item.month + 4'd1;
                fwd_level = LVL_MONTH;
            end
        end
    end

    // step back one day; December is always 31 days so year wrap is safe
    assign dim_prev = days_in((i_item.month == 4'd1) ? 4'd12 : i_item.month - 4'd1,
                              i_item.year);

    always_comb begin
        back_wday  = (i_item.wday == 3'd1) ? 3'd7 : i_item.wday - 3'd1;
        back_mday  = i_item.mday - 5'd1;
        back_month = i_item.month;
        back_year  = i_item.year;
        back_level = LVL_DAY;
        if (i_item.mday == 5'd1) begin
            back_mday = dim_prev;
            if (i_item.month == 4'd1) begin
                back_month = 4'd12;
                back_year  = (i_item.year == 7'd0) ? 7'd99 : i_item.year - 7'd1;
                back_level = LVL_YEAR;
            end else begin
                back_month = i_item.month - 4'd1;
                back_level = LVL_MONTH;
            end
        end
    end

    assign hour_sum  = {1'b0, i_item.hour} + {2'b00, off};
    assign hour_wrap = {1'b0, i_item.hour} + 6'd24 - {2'b00, off};

    always_comb begin
        o_res.sec     = i_item.sec;
        o_res.min     = i_item.min;
        o_res.hour    = i_item.hour;
        o_res.wday    = i_item.wday;
        o_res.mday    = i_item.mday;
        o_res.month   = i_item.month;
        o_res.year    = i_item.year;
        o_res.level   = LVL_SEC;
        o_res.off     = off;
        o_res.invalid = bad;
        if (!bad) begin
            case (i_item.cmd)
                CMD_ADD_SEC: begin
                    if (i_item.sec < 6'd59) begin
                        o_res.sec = i_item.sec + 6'd1;
                    end else if (i_item.min < 6'd59) begin
                        o_res.sec   = '0;
                        o_res.min   = i_item.min + 6'd1;
                        o_res.level = LVL_MIN;
                    end else if (i_item.hour < 5'd23) begin
                        o_res.sec   = '0;
                        o_res.min   = '0;
                        o_res.hour  = i_item.hour + 5'd1;
                        o_res.level = LVL_HOUR;
                    end else begin
                        o_res.sec   = '0;
                        o_res.min   = '0;
                        o_res.hour  = '0;
                        o_res.wday  = fwd_wday;
                        o_res.mday  = fwd_mday;
                        o_res.month = fwd_month;
                        o_res.year  = fwd_year;
                        o_res.level = fwd_level;
                    end
                end
                CMD_NEXT_DAY: begin
                    o_res.wday  = fwd_wday;
                    o_res.mday  = fwd_mday;
                    o_res.month = fwd_month;
                    o_res.year  = fwd_year;
                    o_res.level = fwd_level;
                end
                CMD_PREV_DAY: begin
                    o_res.wday  = back_wday;
                    o_res.mday  = back_mday;
                    o_res.month = back_month;
                    o_res.year  = back_year;
                    o_res.level = back_level;
                end
                CMD_TO_LOCAL: begin
                    o_res.level = LVL_HOUR;
                    o_res.hour  = hour_sum[W_HOUR-1:0];
                    if (hour_sum > 6'd23) begin
                        o_res.hour  = hour_sum[W_HOUR-1:0] - 5'd24;
                        o_res.wday  = fwd_wday;
                        o_res.mday  = fwd_mday;
                        o_res.month = fwd_month;
                        o_res.year  = fwd_year;
                        o_res.level = fwd_level;
                    end
                end
                default: begin
                    o_res.level = LVL_HOUR;
                    if ({1'b0, i_item.hour} >= {2'b00, off}) begin
                        o_res.hour = i_item.hour - {1'b0, off};
                    end else begin
                        o_res.hour  = hour_wrap[W_HOUR-1:0];
                        o_res.wday  = back_wday;
                        o_res.mday  = back_mday;
                        o_res.month = back_month;
                        o_res.year  = back_year;
                        o_res.level = back_level;
                    end
                end
            endcase
        end
    end

endmodule

>>> design/calendar_step_and_dst_convert_core.sv
// ----------------------------------------------------------------------------
// calendar_step_and_dst_convert_core
// Date-time step and UTC/local conversion under the European daylight rule.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one date-time item per handshake, command on tuser.
//   Master stream: the updated date-time, the highest field changed, the
//   local offset seen on the input time, and an invalid flag on tuser.
//   Config port: write register 0 (standard offset, hours east of UTC,
//   clamped to 12) or register 1 (daylight enable) while no item is in
//   flight; both take effect on the next item computed.
// Timing:
//   An accepted item lands in the input register, is worked out in one
//   pass and is caught in the result register once that register is free.
//   One item per cycle is sustained while the receiver keeps tready high;
//   the rate is set by the single combinational pass between the two stages.
// Reset:
//   Both stages empty; the offset register returns to 1 and daylight
//   saving to enabled.
// Stall:
//   While the receiver holds tready low, the result register holds its item
//   and the input register still takes one more item; after that tready on
//   the slave side drops until the result is taken.
// ----------------------------------------------------------------------------
module calendar_step_and_dst_convert_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [cscd_pkg::W_CFG_INDEX-1:0] i_cfg_index,
    input  logic [cscd_pkg::W_CFG_DATA-1:0]  i_cfg_wdata,
    // slave stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // sec[5:0] min[11:6] hour[16:12] weekday[19:17] mday[24:20]
    // month[28:25] year[35:29], zero pad [39:36]
    input  logic [cscd_pkg::W_S_TDATA-1:0]   s_tdata,
    // cmd[2:0]
    input  logic [cscd_pkg::W_S_TUSER-1:0]   s_tuser,
    // master stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // sec[5:0] min[11:6] hour[16:12] weekday[19:17] mday[24:20]
    // month[28:25] year[35:29] change_level[38:36] offset_used[42:39],
    // zero pad [47:43]
    output logic [cscd_pkg::W_M_TDATA-1:0]   m_tdata,
    // input_invalid[0]
    output logic                             m_tuser
);
    import cscd_pkg::*;

    t_cfg cfg;
    t_in  in_item;
    t_out res;

    logic r_in_valid;
    t_in  r_in;
    logic r_out_valid;
    t_out r_out;

    logic out_free;
    logic in_take;

    cscd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // unpack the slave payload
    assign in_item.cmd   = s_tuser;
    assign in_item.sec   = s_tdata[5:0];
    assign in_item.min   = s_tdata[11:6];
    assign in_item.hour  = s_tdata[16:12];
    assign in_item.wday  = s_tdata[19:17];
    assign in_item.mday  = s_tdata[24:20];
    assign in_item.month = s_tdata[28:25];
    assign in_item.year  = s_tdata[35:29];

    // result register frees when empty or when its item leaves this cycle
    assign out_free = !r_out_valid || m_tready;
    // input register advances into the result register whenever it can
    assign s_tready = !r_in_valid || out_free;
    assign in_take  = s_tvalid && s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= in_item;
        end
    end

    cscd_calc u_calc (
        .i_item (r_in),
        .i_cfg  (cfg),
        .o_res  (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    // hold the result while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (out_free && r_in_valid) begin
            r_out <= res;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {5'b00000, r_out.off, r_out.level, r_out.year, r_out.month,
                       r_out.mday, r_out.wday, r_out.hour, r_out.min, r_out.sec};
    assign m_tuser  = r_out.invalid;

endmodule

>>> design/cscd_chk.sv
// ----------------------------------------------------------------------------
// cscd_chk
// Port-level checks on the result stream of the calendar core.
// ----------------------------------------------------------------------------
module cscd_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [cscd_pkg::W_M_TDATA-1:0] m_tdata,
    input logic                           m_tuser
);
    import cscd_pkg::*;

    // a stalled result holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // a reset edge leaves the result stage empty
    assert property (@(posedge i_clk) !i_rst_n |=> !m_tvalid)
        else $error("result valid after reset");

    // invalid items report no change and no offset
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser |-> m_tdata[38:36] == LVL_SEC && m_tdata[42:39] == 4'd0)
        else $error("invalid item carries level or offset");

    // valid items leave a time of day in range and a bounded offset
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tuser |-> m_tdata[5:0] <= 6'd59 && m_tdata[11:6] <= 6'd59 &&
        m_tdata[16:12] <= 5'd23 && m_tdata[42:39] <= 4'd13 &&
        m_tdata[38:36] <= LVL_YEAR)
        else $error("result field out of range");

endmodule

bind calendar_step_and_dst_convert_core cscd_chk u_cscd_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the calendar step and DST convert core.
// Streams directed and random date-time items through the core under several
// offset and daylight settings and several handshake patterns. A calendar
// model in the bench works out each result as the item is accepted; a monitor
// compares every result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import cscd_pkg::*;

    localparam int CLK_HALF     = 2;
    localparam int RESET_CYCLES = 9;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_PAD    = 4;
    localparam int MAX_PRINTS   = 30;

    // first command code past the defined ones
    localparam logic [W_CMD-1:0] CMD_UNDEFINED = 3'd5;

    // working copy of a date-time with room for intermediate hours
    typedef struct {
        int sec;
        int min;
        int hour;
        int wday;
        int mday;
        int month;
        int year;
        int level;
    } cal_t;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_we    = 1'b0;
    logic [W_CFG_INDEX-1:0] i_cfg_index = '0;
    logic [W_CFG_DATA-1:0]  i_cfg_wdata = '0;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    logic [W_S_TDATA-1:0]   s_tdata     = '0;
    logic [W_S_TUSER-1:0]   s_tuser     = '0;
    logic                   m_tvalid;
    logic                   m_tready    = 1'b0;
    logic [W_M_TDATA-1:0]   m_tdata;
    logic                   m_tuser;

    // predictions in acceptance order
    t_out expected_dates[$];

    // bench copy of the two registers
    logic [W_OFF-1:0] cfg_std_offset = STD_OFFSET_RESET;
    logic             cfg_dst_en     = 1'b1;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    logic        hold_start     = 1'b0;
    int unsigned hold_left      = 0;

    int unsigned error_count     = 0;
    int unsigned items_sent      = 0;
    int unsigned results_checked = 0;
    int unsigned config_writes   = 0;
    int unsigned cycle_count     = 0;

    calendar_step_and_dst_convert_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Calendar model
    // ------------------------------------------------------------------
    function automatic int month_days(input int month, input int year);
        int n;
        case (month)
            1, 3, 5, 7, 8, 10, 12: n = 31;
            4, 6, 9, 11:           n = 30;
            2:                     n = (year % 4 == 0) ? 29 : 28;
            default:               n = 0;
        endcase
        return n;
    endfunction

    function automatic cal_t advance_day(input cal_t c);
        c.wday = (c.wday == 7) ? 1 : c.wday + 1;
        if (c.mday == month_days(c.month, c.year)) begin
            c.mday = 1;
            if (c.month == 12) begin
                c.month = 1;
                c.year  = (c.year == 99) ? 0 : c.year + 1;
                c.level = int'(LVL_YEAR);
            end else begin
                c.month++;
                c.level = int'(LVL_MONTH);
            end
        end else begin
            c.mday++;
            c.level = int'(LVL_DAY);
        end
        return c;
    endfunction

    function automatic cal_t retreat_day(input cal_t c);
        c.wday = (c.wday == 1) ? 7 : c.wday - 1;
        if (c.mday != 1) begin
            c.mday--;
            c.level = int'(LVL_DAY);
        end else if (c.month == 1) begin
            c.month = 12;
            c.year  = (c.year == 0) ? 99 : c.year - 1;
            c.mday  = month_days(c.month, c.year);
            c.level = int'(LVL_YEAR);
        end else begin
            c.month--;
            c.mday  = month_days(c.month, c.year);
            c.level = int'(LVL_MONTH);
        end
        return c;
    endfunction

    // European rule: last Sunday of March to last Sunday of October
    function automatic bit daylight_active(input cal_t c);
        int  dow;
        bit  last_sun;
        dow      = c.wday % 7;
        last_sun = (c.mday >= 25) && (dow == 0);
        if (c.month > 3 && c.month < 10)
            return 1'b1;
        if (c.month == 3)
            return last_sun ? (c.hour > 0) : ((c.mday - dow) >= 25);
        if (c.month == 10)
            return last_sun ? (c.hour < 1) : ((c.mday - dow) < 25);
        return 1'b0;
    endfunction

    function automatic t_out step_calendar(input t_in x, input logic [W_OFF-1:0] std_off,
                                           input logic dst_en);
        cal_t c;
        t_out r;
        int   off;
        bit   bad;
        c.sec   = int'(x.sec);
        c.min   = int'(x.min);
        c.hour  = int'(x.hour);
        c.wday  = int'(x.wday);
        c.mday  = int'(x.mday);
        c.month = int'(x.month);
        c.year  = int'(x.year);
        c.level = int'(LVL_SEC);
        off     = 0;
        bad = (x.cmd > CMD_FROM_LOCAL) || (c.sec > 59) || (c.min > 59) || (c.hour > 23) ||
              (c.wday < 1) || (c.wday > 7) || (c.month < 1) || (c.month > 12) ||
              (c.year > 99) || (c.mday < 1) || (c.mday > month_days(c.month, c.year));
        if (!bad) begin
            off = (std_off > STD_OFFSET_MAX) ? int'(STD_OFFSET_MAX) : int'(std_off);
            if (dst_en && daylight_active(c))
                off++;
            case (x.cmd)
                CMD_ADD_SEC: begin
                    if (c.sec < 59) begin
                        c.sec++;
                        c.level = int'(LVL_SEC);
                    end else if (c.min < 59) begin
                        c.sec = 0;
                        c.min++;
                        c.level = int'(LVL_MIN);
                    end else if (c.hour < 23) begin
                        c.sec = 0;
                        c.min = 0;
                        c.hour++;
                        c.level = int'(LVL_HOUR);
                    end else begin
                        c.sec  = 0;
                        c.min  = 0;
                        c.hour = 0;
                        c = advance_day(c);
                    end
                end
                CMD_NEXT_DAY: c = advance_day(c);
                CMD_PREV_DAY: c = retreat_day(c);
                CMD_TO_LOCAL: begin
                    c.hour += off;
                    c.level = int'(LVL_HOUR);
                    if (c.hour > 23) begin
                        c.hour -= 24;
                        c = advance_day(c);
                    end
                end
                default: begin
                    c.level = int'(LVL_HOUR);
                    if (c.hour >= off) begin
                        c.hour -= off;
                    end else begin
                        c.hour += 24 - off;
                        c = retreat_day(c);
                    end
                end
            endcase
        end
        r.sec     = W_SEC'(c.sec);
        r.min     = W_MIN'(c.min);
        r.hour    = W_HOUR'(c.hour);
        r.wday    = W_WDAY'(c.wday);
        r.mday    = W_MDAY'(c.mday);
        r.month   = W_MONTH'(c.month);
        r.year    = W_YEAR'(c.year);
        r.level   = W_LEVEL'(c.level);
        r.off     = W_OFF'(off);
        r.invalid = bad;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Item builders
    // ------------------------------------------------------------------
    function automatic t_in make_dt(input logic [W_CMD-1:0] cmd, input int sec, input int min,
                                    input int hour, input int wday, input int mday,
                                    input int month, input int year);
        t_in x;
        x.cmd   = cmd;
        x.sec   = W_SEC'(sec);
        x.min   = W_MIN'(min);
        x.hour  = W_HOUR'(hour);
        x.wday  = W_WDAY'(wday);
        x.mday  = W_MDAY'(mday);
        x.month = W_MONTH'(month);
        x.year  = W_YEAR'(year);
        return x;
    endfunction

    // Mostly well-formed dates leaning on month ends, the two switch-over
    // months and Sundays; a few raw or single-field-broken items.
    function automatic t_in random_item();
        t_in x;
        int  pick;
        int  len;
        pick    = $urandom_range(99);
        x.cmd   = W_CMD'($urandom_range(int'(CMD_FROM_LOCAL)));
        x.year  = W_YEAR'($urandom_range(99));
        x.month = W_MONTH'(($urandom_range(99) < 40) ? (($urandom_range(1) != 0) ? 3 : 10)
                                                     : $urandom_range(12, 1));
        len     = month_days(int'(x.month), int'(x.year));
        x.mday  = W_MDAY'(($urandom_range(99) < 45) ? len - int'($urandom_range(6))
                                                    : int'($urandom_range(len, 1)));
        x.wday  = W_WDAY'(($urandom_range(99) < 35) ? 7 : $urandom_range(7, 1));
        case ($urandom_range(5))
            0:       x.hour = W_HOUR'(0);
            1:       x.hour = W_HOUR'(1);
            2:       x.hour = W_HOUR'(23);
            default: x.hour = W_HOUR'($urandom_range(23));
        endcase
        x.min = W_MIN'(($urandom_range(99) < 30) ? 59 : $urandom_range(59));
        x.sec = W_SEC'(($urandom_range(99) < 30) ? 59 : $urandom_range(59));
        if (pick < 8) begin
            // raw noise over every bit
            x.cmd   = W_CMD'($urandom);
            x.sec   = W_SEC'($urandom);
            x.min   = W_MIN'($urandom);
            x.hour  = W_HOUR'($urandom);
            x.wday  = W_WDAY'($urandom);
            x.mday  = W_MDAY'($urandom);
            x.month = W_MONTH'($urandom);
            x.year  = W_YEAR'($urandom);
        end else if (pick < 16) begin
            // break exactly one field
            case ($urandom_range(7))
                0: x.cmd  = W_CMD'($urandom_range(7, int'(CMD_FROM_LOCAL) + 1));
                1: x.sec  = W_SEC'($urandom_range(63, 60));
                2: x.min  = W_MIN'($urandom_range(63, 60));
                3: x.hour = W_HOUR'($urandom_range(31, 24));
                4: x.wday = W_WDAY'(0);
                5: x.mday = W_MDAY'((len < 31) ? $urandom_range(31, len + 1) : 0);
                6: x.month = W_MONTH'(($urandom_range(1) != 0) ? 0 : $urandom_range(15, 13));
                default: x.year = W_YEAR'($urandom_range(127, 100));
            endcase
        end
        return x;
    endfunction

    // ------------------------------------------------------------------
    // Shared driver tasks
    // ------------------------------------------------------------------
    task automatic send_item(input t_in x);
        // idle the sender at random before offering
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, x.year, x.month, x.mday, x.wday, x.hour, x.min, x.sec};
        s_tuser  <= x.cmd;
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        expected_dates.push_back(step_calendar(x, cfg_std_offset, cfg_dst_en));
        items_sent++;
    endtask

    // drop valid, wait for every result, then cover the pipeline latency
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_dates.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [W_CFG_INDEX-1:0] index,
                                input logic [W_CFG_DATA-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (index == CFG_STD_OFFSET)
            cfg_std_offset = data;
        else
            cfg_dst_en = data[0];
        config_writes++;
    endtask

    task automatic set_offsets(input int std_off, input bit dst);
        write_config(CFG_STD_OFFSET, W_CFG_DATA'(std_off));
        // upper data bits are don't-care for the enable
        write_config(CFG_DST_EN, {3'($urandom_range(7)), dst});
    endtask

    task automatic send_random_burst(input int n);
        repeat (n) send_item(random_item());
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Runs on the reset settings: offset 1 with daylight enabled.
    task automatic test_directed();
        send_item(make_dt(CMD_ADD_SEC,    0,  0,  0, 1,  1,  1,  0));
        send_item(make_dt(CMD_ADD_SEC,   59,  0, 12, 3, 15,  6, 21));
        send_item(make_dt(CMD_ADD_SEC,   59, 59,  5, 3, 15,  6, 21));
        send_item(make_dt(CMD_ADD_SEC,   59, 59, 23, 7, 31, 12, 99));
        send_item(make_dt(CMD_ADD_SEC,   59, 59, 23, 2, 30,  4, 50));
        // leap and common February
        send_item(make_dt(CMD_NEXT_DAY,   0,  0,  0, 4, 28,  2,  4));
        send_item(make_dt(CMD_NEXT_DAY,   0,  0,  0, 4, 28,  2,  3));
        send_item(make_dt(CMD_NEXT_DAY,  10, 20,  8, 5, 29,  2, 96));
        // year wrap backward, back into February
        send_item(make_dt(CMD_PREV_DAY,   0,  0,  0, 6,  1,  1,  0));
        send_item(make_dt(CMD_PREV_DAY,   0,  0,  0, 1,  1,  3,  8));
        send_item(make_dt(CMD_PREV_DAY,   0,  0,  0, 1,  1,  3,  7));
        // March switch-over: last Sunday at hour 0, hour 1, after, before
        send_item(make_dt(CMD_TO_LOCAL,   0,  0,  0, 7, 31,  3, 24));
        send_item(make_dt(CMD_TO_LOCAL,   0,  0,  1, 7, 31,  3, 24));
        send_item(make_dt(CMD_TO_LOCAL,   0,  0, 12, 1, 30,  3, 24));
        send_item(make_dt(CMD_TO_LOCAL,   0,  0, 12, 6, 24,  3, 24));
        // October switch-over on the last Sunday, hour 0 then hour 1
        send_item(make_dt(CMD_FROM_LOCAL, 0,  0,  0, 7, 27, 10, 24));
        send_item(make_dt(CMD_FROM_LOCAL, 0,  0,  1, 7, 27, 10, 24));
        // conversions that cross the year
        send_item(make_dt(CMD_TO_LOCAL,  59, 59, 23, 7, 31, 12, 99));
        send_item(make_dt(CMD_FROM_LOCAL, 0,  0,  0, 1,  1,  1,  0));
        // invalid input passes through with the flag set
        send_item(make_dt(CMD_UNDEFINED,  0,  0,  0, 1,  1,  1,  0));
        send_item(make_dt(CMD_ADD_SEC,   60,  0,  0, 1,  1,  1,  0));
        send_item(make_dt(CMD_NEXT_DAY,   0, 63, 31, 1,  1,  1,  0));
        send_item(make_dt(CMD_PREV_DAY,   0,  0,  0, 0,  1,  1,  0));
        send_item(make_dt(CMD_NEXT_DAY,   0,  0,  0, 3, 31,  4, 10));
        send_item(make_dt(CMD_TO_LOCAL,   0,  0,  0, 3, 29,  2, 11));
        send_item(make_dt(CMD_ADD_SEC,    0,  0,  0, 3,  1,  0, 10));
        send_item(make_dt(CMD_ADD_SEC,    0,  0,  0, 3,  1, 15, 127));
        wait_drained();
    endtask

    // Sweep offsets across the clamp and both daylight settings.
    task automatic test_config_sweep();
        int offsets[5];
        offsets = '{0, 12, 15, 13, 5};
        foreach (offsets[k]) begin
            for (int dst = 0; dst < 2; dst++) begin
                set_offsets(offsets[k], dst[0]);
                send_random_burst(20);
                wait_drained();
            end
        end
    endtask

    task automatic test_random_phase(input int n, input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        set_offsets($urandom_range(15), 1'($urandom_range(1)));
        send_random_burst(n);
        wait_drained();
    endtask

    // Hold the receiver off long enough to fill both stages while the
    // sender keeps offering, then pause the sender until all results land.
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_start <= 1'b1;
        @(posedge i_clk);
        hold_start <= 1'b0;
        send_random_burst(40);
        wait_drained();
        send_random_burst(10);
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Receiver side
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_start)
            hold_left <= HOLD_CYCLES;
    end

    always @(posedge i_clk) begin
        if (hold_left != 0 || hold_start)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("%0t ns: mismatch on %s, got %0d, want %0d", $time, what, got, want);
    endtask

    task automatic check_field(input string what, input int got, input int want);
        if (got != want)
            report_mismatch(what, got, want);
    endtask

    // compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin : result_monitor
        t_out want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (expected_dates.size() == 0) begin
                report_mismatch("result with nothing pending", int'(m_tdata[31:0]), 0);
            end else begin
                want = expected_dates.pop_front();
                results_checked++;
                check_field("sec",          int'(m_tdata[5:0]),   int'(want.sec));
                check_field("min",          int'(m_tdata[11:6]),  int'(want.min));
                check_field("hour",         int'(m_tdata[16:12]), int'(want.hour));
                check_field("weekday",      int'(m_tdata[19:17]), int'(want.wday));
                check_field("mday",         int'(m_tdata[24:20]), int'(want.mday));
                check_field("month",        int'(m_tdata[28:25]), int'(want.month));
                check_field("year",         int'(m_tdata[35:29]), int'(want.year));
                check_field("change_level", int'(m_tdata[38:36]), int'(want.level));
                check_field("offset_used",  int'(m_tdata[42:39]), int'(want.off));
                check_field("tdata pad",    int'(m_tdata[47:43]), 0);
                check_field("input_invalid", int'(m_tuser),       int'(want.invalid));
            end
        end
    end

    // ------------------------------------------------------------------
    // Run control
    // ------------------------------------------------------------------
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results pending", cycle_count,
                 expected_dates.size());
        $display("[calendar_step_and_dst_convert_core] ERROR");
        $finish;
    end

    initial begin : stimulus
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_config_sweep();
        test_random_phase(300, 0, 0);
        test_random_phase(300, 85, 0);
        test_random_phase(300, 0, 85);
        test_random_phase(300, 6, 6);
        test_backpressure();
        wait_drained();
        $display("Sent %0d items, checked %0d results across %0d register writes.",
                 items_sent, results_checked, config_writes);
        $display("Covered all commands, invalid fields, offset clamp, DST edges and stalls.");
        if (error_count == 0)
            $display("[calendar_step_and_dst_convert_core] OK");
        else
            $display("[calendar_step_and_dst_convert_core] ERROR");
        $finish;
    end

endmodule
